>>> rtl/rfwg_pkg.sv
// Package for the rectangle fill write generator.
// Holds coordinate width, command codes, register indexes and outline segment codes.
// No dependencies.
package rfwg_pkg;

  // Coordinate width; edge coordinates carry one more bit
  localparam int COORD_BITS = 12;
  localparam int EDGE_BITS  = COORD_BITS + 1;

  // Field and register widths
  localparam int CMD_BITS   = 2;
  localparam int COLOR_BITS = 24;
  localparam int ADDR_BITS  = 32;
  localparam int PITCH_BITS = 16;
  localparam int PB_BITS    = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_FILL_RECT    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_OUTLINE_RECT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_FILL_SCREEN  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_STEP         = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_PITCH    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_BYTES   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 3'd4;

  // Configuration reset values
  localparam logic [ADDR_BITS-1:0]  RST_BASE_ADDRESS  = 32'd0;
  localparam logic [PITCH_BITS-1:0] RST_LINE_PITCH    = 16'd3072;
  localparam logic [PB_BITS-1:0]    RST_PIXEL_BYTES   = 3'd3;
  localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(768);

  // Job kinds
  localparam logic KIND_FILLED  = 1'b0;
  localparam logic KIND_OUTLINE = 1'b1;

  // Outline segments, in drawing order
  localparam logic [1:0] SEG_LEFT   = 2'd0;
  localparam logic [1:0] SEG_RIGHT  = 2'd1;
  localparam logic [1:0] SEG_TOP    = 2'd2;
  localparam logic [1:0] SEG_BOTTOM = 2'd3;

endpackage

>>> rtl/rectangle_fill_write_generator_unit.sv
// Rectangle fill write generator: turns drawing jobs into a stream of pixel writes.
// Depends on rfwg_pkg.
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  cmd, pos_x, pos_y, rect_width, rect_height,
//                                           draw_color
//   out_      output     out_valid/out_stall write_address, pixel_color, last_write
//   cfg_      input      cfg_wr_en          cfg_index, cfg_wdata
//
// One request per clock unless in_stall is high: a request waits in the input register,
// the job state and the address (a y*pitch and an x*bytes multiply plus a three-way add)
// are computed from it, and the write lands in the result register, so out_valid rises
// once a step of an active job has passed both registers. out_stall holds the result
// register and, once the input register is also occupied, raises in_stall. Reset
// (rst_n low, synchronous) empties both registers, idles the job and restores
// register defaults.
module rectangle_fill_write_generator_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic [rfwg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [rfwg_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [rfwg_pkg::CMD_BITS-1:0]           in_cmd,
  input  logic [rfwg_pkg::COORD_BITS-1:0]         in_pos_x,
  input  logic [rfwg_pkg::COORD_BITS-1:0]         in_pos_y,
  input  logic [rfwg_pkg::COORD_BITS-1:0]         in_rect_width,
  input  logic [rfwg_pkg::COORD_BITS-1:0]         in_rect_height,
  input  logic [rfwg_pkg::COLOR_BITS-1:0]         in_draw_color,
  // write channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [rfwg_pkg::ADDR_BITS-1:0]          out_write_address,
  output logic [rfwg_pkg::COLOR_BITS-1:0]         out_pixel_color,
  output logic                                    out_last_write
);
  import rfwg_pkg::*;

  // configuration registers
  logic [ADDR_BITS-1:0]  base_address_r;
  logic [PITCH_BITS-1:0] line_pitch_r;
  logic [PB_BITS-1:0]    pixel_bytes_r;
  logic [COORD_BITS-1:0] screen_width_r;
  logic [COORD_BITS-1:0] screen_height_r;

  // input register
  logic                  in_valid_r;
  logic [CMD_BITS-1:0]   cmd_r;
  logic [COORD_BITS-1:0] pos_x_r;
  logic [COORD_BITS-1:0] pos_y_r;
  logic [COORD_BITS-1:0] rect_w_r;
  logic [COORD_BITS-1:0] rect_h_r;
  logic [COLOR_BITS-1:0] draw_color_r;

  // job state
  logic                  job_active_r, job_active_nxt;
  logic                  job_kind_r, job_kind_nxt;
  logic [1:0]            seg_r, seg_nxt;
  logic [COORD_BITS-1:0] org_x_r, org_x_nxt;
  logic [COORD_BITS-1:0] org_y_r, org_y_nxt;
  logic [COORD_BITS-1:0] span_w_r, span_w_nxt;
  logic [COORD_BITS-1:0] span_h_r, span_h_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COLOR_BITS-1:0] job_color_r, job_color_nxt;

  // result register
  logic                  out_valid_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  last_r;

  // handshake
  logic advance, fire, in_accept;
  logic res_valid, res_last;
  logic [EDGE_BITS-1:0] px, py;
  logic [EDGE_BITS-1:0] col_inc, row_inc;
  logic col_end, row_end;
  logic [EDGE_BITS+PITCH_BITS-1:0] row_off;
  logic [EDGE_BITS+PB_BITS-1:0]    col_off;
  logic [ADDR_BITS-1:0]            addr_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r  <= RST_BASE_ADDRESS;
      line_pitch_r    <= RST_LINE_PITCH;
      pixel_bytes_r   <= RST_PIXEL_BYTES;
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:  base_address_r  <= cfg_wdata[ADDR_BITS-1:0];
        CFG_LINE_PITCH:    line_pitch_r    <= cfg_wdata[PITCH_BITS-1:0];
        CFG_PIXEL_BYTES:   pixel_bytes_r   <= cfg_wdata[PB_BITS-1:0];
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[COORD_BITS-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r        <= in_cmd;
      pos_x_r      <= in_pos_x;
      pos_y_r      <= in_pos_y;
      rect_w_r     <= in_rect_width;
      rect_h_r     <= in_rect_height;
      draw_color_r <= in_draw_color;
    end
  end

  // end-of-span tests
  assign col_inc = {1'b0, col_r} + EDGE_BITS'(1);
  assign row_inc = {1'b0, row_r} + EDGE_BITS'(1);
  assign col_end = col_inc >= {1'b0, span_w_r};
  assign row_end = row_inc >= {1'b0, span_h_r};

  // job update and pixel position for the request in the input register
  always_comb begin
    job_active_nxt = job_active_r;
    job_kind_nxt   = job_kind_r;
    seg_nxt        = seg_r;
    org_x_nxt      = org_x_r;
    org_y_nxt      = org_y_r;
    span_w_nxt     = span_w_r;
    span_h_nxt     = span_h_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    job_color_nxt  = job_color_r;
    res_valid      = 1'b0;
    res_last       = 1'b0;
    px             = {1'b0, org_x_r} + {1'b0, col_r};
    py             = {1'b0, org_y_r} + {1'b0, row_r};
    case (cmd_r)
      CMD_FILL_RECT, CMD_OUTLINE_RECT, CMD_FILL_SCREEN: begin
        job_kind_nxt  = (cmd_r == CMD_OUTLINE_RECT) ? KIND_OUTLINE : KIND_FILLED;
        org_x_nxt     = (cmd_r == CMD_FILL_SCREEN) ? '0 : pos_x_r;
        org_y_nxt     = (cmd_r == CMD_FILL_SCREEN) ? '0 : pos_y_r;
        span_w_nxt    = (cmd_r == CMD_FILL_SCREEN) ? screen_width_r : rect_w_r;
        span_h_nxt    = (cmd_r == CMD_FILL_SCREEN) ? screen_height_r : rect_h_r;
        job_color_nxt = draw_color_r;
        seg_nxt       = SEG_LEFT;
        col_nxt       = '0;
        row_nxt       = '0;
        job_active_nxt = (span_w_nxt != '0) && (span_h_nxt != '0);
      end
      CMD_STEP: begin
        if (job_active_r) begin
          res_valid = 1'b1;
          if (job_kind_r == KIND_FILLED) begin
            // row-major walk
            res_last = col_end && row_end;
            if (col_end) begin
              col_nxt = '0;
              row_nxt = row_inc[COORD_BITS-1:0];
            end else begin
              col_nxt = col_inc[COORD_BITS-1:0];
            end
          end else if (seg_r == SEG_LEFT || seg_r == SEG_RIGHT) begin
            // vertical edges
            px = (seg_r == SEG_LEFT) ? {1'b0, org_x_r}
                                     : {1'b0, org_x_r} + {1'b0, span_w_r} - EDGE_BITS'(1);
            if (row_end) begin
              row_nxt = '0;
              seg_nxt = seg_r + 2'd1;
            end else begin
              row_nxt = row_inc[COORD_BITS-1:0];
            end
          end else begin
            // horizontal edges
            py = (seg_r == SEG_TOP) ? {1'b0, org_y_r}
                                    : {1'b0, org_y_r} + {1'b0, span_h_r} - EDGE_BITS'(1);
            if (col_end) begin
              col_nxt  = '0;
              res_last = (seg_r == SEG_BOTTOM);
              seg_nxt  = seg_r + 2'd1;
            end else begin
              col_nxt = col_inc[COORD_BITS-1:0];
            end
          end
          if (res_last) begin
            job_active_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // byte address: base + y*pitch + x*bytes, wrapping at 32 bits
  assign row_off  = {{PITCH_BITS{1'b0}}, py} * {{EDGE_BITS{1'b0}}, line_pitch_r};
  assign col_off  = {{PB_BITS{1'b0}}, px} * {{EDGE_BITS{1'b0}}, pixel_bytes_r};
  assign addr_nxt = base_address_r + ADDR_BITS'(row_off) + ADDR_BITS'(col_off);

  // job state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
      job_kind_r   <= KIND_FILLED;
      seg_r        <= SEG_LEFT;
      org_x_r      <= '0;
      org_y_r      <= '0;
      span_w_r     <= '0;
      span_h_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
      job_color_r  <= '0;
    end else if (fire) begin
      job_active_r <= job_active_nxt;
      job_kind_r   <= job_kind_nxt;
      seg_r        <= seg_nxt;
      org_x_r      <= org_x_nxt;
      org_y_r      <= org_y_nxt;
      span_w_r     <= span_w_nxt;
      span_h_r     <= span_h_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      job_color_r  <= job_color_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      addr_r  <= addr_nxt;
      color_r <= job_color_r;
      last_r  <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_last_write    = last_r;

endmodule
